[rtl/stl_pkg.sv]
package stl_pkg;

    // lexer mode, held between words
    typedef enum logic [2:0] {
        MODE_IDLE   = 3'd0,
        MODE_STRING = 3'd1,
        MODE_VECTOR = 3'd2,
        MODE_NUMBER = 3'd3,
        MODE_SKIP   = 3'd4
    } lex_mode_t;

    // token kinds
    localparam logic [3:0] KIND_UNKNOWN = 4'd0;
    localparam logic [3:0] KIND_STRING  = 4'd1;
    localparam logic [3:0] KIND_SEMI    = 4'd2;
    localparam logic [3:0] KIND_VECTOR  = 4'd3;
    localparam logic [3:0] KIND_OPEN    = 4'd4;
    localparam logic [3:0] KIND_CLOSE   = 4'd5;
    localparam logic [3:0] KIND_NUMBER  = 4'd6;
    localparam logic [3:0] KIND_BOOL    = 4'd7;
    localparam logic [3:0] KIND_COLON   = 4'd8;
    localparam logic [3:0] KIND_COMMA   = 4'd9;
    localparam logic [3:0] KIND_UNTERM  = 4'd10;

    localparam int SkipW = 3;

    // one result word
    typedef struct packed {
        logic [3:0] token_kind;
        logic [7:0] value_char;
        logic       char_valid;
        logic       bool_value;
        logic       token_end;
    } token_t;

    // what one input word produces
    typedef struct packed {
        logic [1:0]       count;
        token_t           tok0;
        token_t           tok1;
        lex_mode_t        mode_next;
        logic [SkipW-1:0] skip_next;
    } lex_step_t;

endpackage

[rtl/stl_decode.sv]
module stl_decode (
    input  logic [7:0]               char_in,
    input  logic                     end_of_stream,
    input  stl_pkg::lex_mode_t       mode,
    input  logic [stl_pkg::SkipW-1:0] skip_left,
    output stl_pkg::lex_step_t       step
);
    import stl_pkg::*;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_LBRC  = 8'h7B;
    localparam logic [7:0] CH_RBRC  = 8'h7D;
    localparam logic [7:0] CH_F_LO  = 8'h66;
    localparam logic [7:0] CH_F_UP  = 8'h46;
    localparam logic [7:0] CH_T_LO  = 8'h74;
    localparam logic [7:0] CH_T_UP  = 8'h54;

    typedef struct packed {
        lex_mode_t        mode;
        logic             emit;
        token_t           tok;
        logic             set_skip;
        logic [SkipW-1:0] skip;
    } class_t;

    // classification of a byte seen in idle, also of the byte that ends a number
    function automatic class_t classify(input logic [7:0] c);
        class_t r;
        r          = '0;
        r.mode     = MODE_IDLE;
        r.emit     = 1'b1;
        r.tok.token_end = 1'b1;
        unique case (c) inside
            CH_SPACE, CH_NL, CH_TAB: r.emit = 1'b0;
            CH_QUOTE: begin
                r.mode = MODE_STRING;
                r.emit = 1'b0;
            end
            CH_LPAR: begin
                r.mode = MODE_VECTOR;
                r.emit = 1'b0;
            end
            CH_MINUS, [CH_ZERO:CH_NINE]: begin
                r.mode           = MODE_NUMBER;
                r.tok.token_kind = KIND_NUMBER;
                r.tok.value_char = c;
                r.tok.char_valid = 1'b1;
                r.tok.token_end  = 1'b0;
            end
            CH_SEMI:  r.tok.token_kind = KIND_SEMI;
            CH_LBRC:  r.tok.token_kind = KIND_OPEN;
            CH_RBRC:  r.tok.token_kind = KIND_CLOSE;
            CH_COLON: r.tok.token_kind = KIND_COLON;
            CH_COMMA: r.tok.token_kind = KIND_COMMA;
            CH_F_LO, CH_F_UP: begin
                r.tok.token_kind = KIND_BOOL;
                r.mode           = MODE_SKIP;
                r.set_skip       = 1'b1;
                r.skip           = SkipW'(4);
            end
            CH_T_LO, CH_T_UP: begin
                r.tok.token_kind = KIND_BOOL;
                r.tok.bool_value = 1'b1;
                r.mode           = MODE_SKIP;
                r.set_skip       = 1'b1;
                r.skip           = SkipW'(3);
            end
            default: r.tok.token_kind = KIND_UNKNOWN;
        endcase
        return r;
    endfunction

    class_t           cls;
    token_t           close_tok;
    logic             is_num;
    logic [SkipW-1:0] skip_dec;

    assign cls      = classify(char_in);
    assign is_num   = (char_in == CH_MINUS) || (char_in == CH_DOT) ||
                      ((char_in >= CH_ZERO) && (char_in <= CH_NINE));
    assign skip_dec = (skip_left != '0) ? skip_left - SkipW'(1) : skip_left;

    always_comb begin
        close_tok           = '0;
        close_tok.token_end = 1'b1;

        step           = '0;
        step.mode_next = mode;
        step.skip_next = skip_left;

        if (end_of_stream) begin
            step.mode_next = MODE_IDLE;
            step.skip_next = '0;
            if (mode == MODE_STRING || mode == MODE_VECTOR) begin
                step.count           = 2'd1;
                step.tok0            = close_tok;
                step.tok0.token_kind = KIND_UNTERM;
            end else if (mode == MODE_NUMBER) begin
                step.count           = 2'd1;
                step.tok0            = close_tok;
                step.tok0.token_kind = KIND_NUMBER;
            end
        end else begin
            unique case (mode)
                MODE_STRING, MODE_VECTOR: begin
                    step.count           = 2'd1;
                    step.tok0.token_kind = (mode == MODE_STRING) ? KIND_STRING : KIND_VECTOR;
                    if ((mode == MODE_STRING && char_in == CH_QUOTE) ||
                        (mode == MODE_VECTOR && char_in == CH_RPAR)) begin
                        step.tok0.token_end = 1'b1;
                        step.mode_next      = MODE_IDLE;
                    end else begin
                        step.tok0.value_char = char_in;
                        step.tok0.char_valid = 1'b1;
                    end
                end
                MODE_NUMBER: begin
                    step.tok0.token_kind = KIND_NUMBER;
                    if (is_num) begin
                        step.count           = 2'd1;
                        step.tok0.value_char = char_in;
                        step.tok0.char_valid = 1'b1;
                    end else begin
                        // number closed, terminator classified afresh
                        step.tok0.token_end = 1'b1;
                        step.count          = cls.emit ? 2'd2 : 2'd1;
                        step.tok1           = cls.tok;
                        step.mode_next      = cls.mode;
                        if (cls.set_skip) begin
                            step.skip_next = cls.skip;
                        end
                    end
                end
                MODE_SKIP: begin
                    step.skip_next = skip_dec;
                    if (skip_dec == '0) begin
                        step.mode_next = MODE_IDLE;
                    end
                end
                default: begin
                    step.count     = cls.emit ? 2'd1 : 2'd0;
                    step.tok0      = cls.tok;
                    step.mode_next = cls.mode;
                    if (cls.set_skip) begin
                        step.skip_next = cls.skip;
                    end
                end
            endcase
        end
    end

endmodule

[rtl/stl_out_fifo.sv]
module stl_out_fifo (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic [1:0]      push_count,
    input  stl_pkg::token_t push_tok0,
    input  stl_pkg::token_t push_tok1,
    output logic            has_room,
    output logic            m_valid,
    input  logic            m_ready,
    output stl_pkg::token_t m_tok
);
    import stl_pkg::*;

    localparam int Depth = 4;
    localparam int PtrW  = $clog2(Depth);
    localparam int CntW  = $clog2(Depth + 1);

    token_t            mem_reg [Depth];
    logic [PtrW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]   count_reg, count_next;
    logic              pop;
    logic [PtrW-1:0]   wr_ptr_p1;

    assign pop       = m_valid && m_ready;
    assign m_valid   = (count_reg != '0);
    assign m_tok     = mem_reg[rd_ptr_reg];
    // room for the two words one input can give
    assign has_room  = (count_reg <= CntW'(Depth - 2));
    assign wr_ptr_p1 = wr_ptr_reg + PtrW'(1);

    always_comb begin
        wr_ptr_next = wr_ptr_reg + PtrW'(push_count);
        rd_ptr_next = rd_ptr_reg + PtrW'(pop);
        count_next  = count_reg + CntW'(push_count) - CntW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_count != 2'd0) begin
            mem_reg[wr_ptr_reg] <= push_tok0;
        end
        if (push_count == 2'd2) begin
            mem_reg[wr_ptr_p1] <= push_tok1;
        end
    end

endmodule

[rtl/script_token_lexer.sv]
// a word is registered on input and decoded from that register; its first result word
//   enters the queue at the edge on which the held word advances, and m_valid is taken from
//   the queue's count register, so a queue without room holds the word back
// throughput: one input word per cycle while the queue has room for two; a number closed
//   by a token byte gives two result words; one output word per cycle then sets the rate
// reset: aresetn synchronous, active low; lexer returns to idle with no skip pending and
//   the result queue is emptied
module script_token_lexer (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic [7:0] s_char_in,
    input  logic       s_end_of_stream,
    input  logic       s_valid,
    output logic       s_ready,
    output logic [3:0] m_token_kind,
    output logic [7:0] m_value_char,
    output logic       m_char_valid,
    output logic       m_bool_value,
    output logic       m_token_end,
    output logic       m_valid,
    input  logic       m_ready
);
    import stl_pkg::*;

    // input register stage
    logic [7:0]       char_reg;
    logic             eos_reg;
    logic             in_valid_reg;

    // lexer state
    lex_mode_t        mode_reg;
    logic [SkipW-1:0] skip_reg;

    lex_step_t        step;
    logic             has_room;
    logic             advance;
    logic [1:0]       push_count;
    token_t           m_tok;

    // the held word moves on only when the queue can take both possible results
    assign advance    = in_valid_reg && has_room;
    assign s_ready    = !in_valid_reg || has_room;
    assign push_count = advance ? step.count : 2'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            mode_reg     <= MODE_IDLE;
            skip_reg     <= '0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                mode_reg <= step.mode_next;
                skip_reg <= step.skip_next;
            end
        end
    end

    // payload, no reset needed
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            char_reg <= s_char_in;
            eos_reg  <= s_end_of_stream;
        end
    end

    // byte classification and next-state logic
    stl_decode u_decode (
        .char_in       (char_reg),
        .end_of_stream (eos_reg),
        .mode          (mode_reg),
        .skip_left     (skip_reg),
        .step          (step)
    );

    // result queue, also the output register
    stl_out_fifo u_out_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_count (push_count),
        .push_tok0  (step.tok0),
        .push_tok1  (step.tok1),
        .has_room   (has_room),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_tok      (m_tok)
    );

    assign m_token_kind = m_tok.token_kind;
    assign m_value_char = m_tok.value_char;
    assign m_char_valid = m_tok.char_valid;
    assign m_bool_value = m_tok.bool_value;
    assign m_token_end  = m_tok.token_end;

    // swallowing after a boolean always has bytes left
    a_skip_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        mode_reg == MODE_SKIP |-> (skip_reg != '0 && skip_reg <= SkipW'(4)))
        else $error("skip mode with no bytes left");

    // end of stream always leaves the lexer clean
    a_eos_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && eos_reg) |=> (mode_reg == MODE_IDLE && skip_reg == '0))
        else $error("lexer not idle after end of stream");

    // a boolean result always starts a swallow
    a_bool_skip: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && !eos_reg && step.count != 2'd0 &&
         ((step.count == 2'd1 && step.tok0.token_kind == KIND_BOOL) ||
          (step.count == 2'd2 && step.tok1.token_kind == KIND_BOOL)))
        |=> mode_reg == MODE_SKIP)
        else $error("boolean token without skip");

    // a held word waiting for queue room is not lost
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !has_room) |=> (in_valid_reg && $stable(char_reg) && $stable(eos_reg)))
        else $error("held word dropped");

endmodule
